@@ hdl/lpfp_pkg.sv @@
// Package with shared types, constants and the type letter decoder of the field parser.
`default_nettype none
package lpfp_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int MAX_FIELDS_DEF  = 8;
    localparam int CFG_BITS        = 16;
    localparam logic [CFG_BITS-1:0] MAX_LEN_RESET = 16'hFFFF;

    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [4:0] TYPE_UNKNOWN = 5'd16;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_LENGTH  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TYPE  = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DIGIT = 2'd1,
        ERR_TRUNC = 2'd2,
        ERR_LIMIT = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        t_kind      item_kind;
        logic [4:0] type_code;
        logic [2:0] field_index;
        logic [7:0] payload_byte;
        logic       field_last;
        logic       message_last;
        t_err       error_code;
    } t_out_word;

    function automatic logic [4:0] lpfp_decode_type(input logic [7:0] b);
        logic [4:0] code;
        case (b)
            8'h4C:   code = 5'd0;   // L
            8'h53:   code = 5'd1;   // S
            8'h52:   code = 5'd2;   // R
            8'h49:   code = 5'd3;   // I
            8'h47:   code = 5'd4;   // G
            8'h42:   code = 5'd5;   // B
            8'h45:   code = 5'd6;   // E
            8'h5A:   code = 5'd7;   // Z
            8'h58:   code = 5'd8;   // X
            8'h4A:   code = 5'd9;   // J
            8'h54:   code = 5'd10;  // T
            8'h41:   code = 5'd11;  // A
            8'h43:   code = 5'd12;  // C
            8'h46:   code = 5'd13;  // F
            8'h56:   code = 5'd14;  // V
            8'h57:   code = 5'd15;  // W
            default: code = TYPE_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

@@ hdl/lpfp_if.sv @@
// Valid/ready channel interfaces for the input bytes, the result items and the configuration write.
`default_nettype none
interface lpfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output first_byte, output final_byte,
                    input ready);
    modport sink (input valid, input data_byte, input first_byte, input final_byte,
                  output ready);
endinterface

interface lpfp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [4:0] type_code;
    logic [2:0] field_index;
    logic [7:0] payload_byte;
    logic       field_last;
    logic       message_last;
    logic [1:0] error_code;

    modport source (output valid, output item_kind, output type_code, output field_index,
                    output payload_byte, output field_last, output message_last,
                    output error_code, input ready);
    modport sink (input valid, input item_kind, input type_code, input field_index,
                  input payload_byte, input field_last, input message_last,
                  input error_code, output ready);
endinterface

interface lpfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/lpfp_step.sv @@
// Next-state and result logic of the field parser for one input word.
`default_nettype none
module lpfp_step #(
    parameter int LENGTH_BITS = 16,
    parameter int MAX_FIELDS  = 8,
    localparam int FieldBits  = $clog2(MAX_FIELDS + 1)
) (
    input  var lpfp_pkg::t_in_word              i_word,
    input  var logic [lpfp_pkg::CFG_BITS-1:0]   i_max_len,
    input  var lpfp_pkg::t_phase                i_phase,
    input  var logic [LENGTH_BITS-1:0]          i_acc,
    input  var logic [LENGTH_BITS-1:0]          i_rem,
    input  var logic [FieldBits-1:0]            i_field,
    input  var logic [4:0]                      i_type,
    input  var logic                            i_digit,
    output lpfp_pkg::t_phase                    o_phase,
    output logic [LENGTH_BITS-1:0]              o_acc,
    output logic [LENGTH_BITS-1:0]              o_rem,
    output logic [FieldBits-1:0]                o_field,
    output logic [4:0]                          o_type,
    output logic                                o_digit,
    output logic                                o_fire,
    output lpfp_pkg::t_out_word                 o_item
);
    import lpfp_pkg::*;

    logic [LENGTH_BITS+3:0]          acc_wide;
    logic [LENGTH_BITS-1:0]          acc_sat;
    logic                            is_digit;
    logic                            is_semi;
    logic                            too_long;
    logic                            too_many;
    logic                            last_byte;
    logic                            fin;

    // Multiply by ten as two shifts; any carry above the length width saturates.
    assign acc_wide = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0}
                    + {{LENGTH_BITS{1'b0}}, i_word.data_byte[3:0]};
    assign acc_sat  = (|acc_wide[LENGTH_BITS+3:LENGTH_BITS]) ? {LENGTH_BITS{1'b1}}
                                                              : acc_wide[LENGTH_BITS-1:0];
    assign is_digit  = (i_word.data_byte >= CHAR_ZERO) && (i_word.data_byte <= CHAR_NINE);
    assign is_semi   = (i_word.data_byte == CHAR_SEMI);
    assign too_long  = {{CFG_BITS{1'b0}}, i_acc} > {{LENGTH_BITS{1'b0}}, i_max_len};
    assign too_many  = i_field >= FieldBits'(MAX_FIELDS);
    assign last_byte = (i_rem[LENGTH_BITS-1:1] == '0);
    assign fin       = i_word.final_byte;

    always_comb begin
        o_phase = i_phase;
        o_acc   = i_acc;
        o_rem   = i_rem;
        o_field = i_field;
        o_type  = i_type;
        o_digit = i_digit;
        o_fire  = 1'b0;
        o_item  = '{item_kind: KIND_ERROR, type_code: i_type, field_index: 3'(i_field),
                    payload_byte: 8'h00, field_last: 1'b0, message_last: 1'b1,
                    error_code: ERR_NONE};

        if (i_word.first_byte) begin
            o_type  = lpfp_decode_type(i_word.data_byte);
            o_field = '0;
            o_rem   = '0;
            o_fire  = 1'b1;
            o_item.item_kind    = KIND_TYPE;
            o_item.type_code    = o_type;
            o_item.field_index  = 3'd0;
            o_item.message_last = fin;
            if (fin) begin
                o_phase = PH_IDLE;
            end else begin
                o_acc   = '0;
                o_digit = 1'b0;
                o_phase = PH_LENGTH;
            end
        end else begin
            case (i_phase)
                PH_LENGTH: begin
                    if (is_digit) begin
                        o_acc   = acc_sat;
                        o_digit = 1'b1;
                        if (fin) begin
                            o_fire            = 1'b1;
                            o_item.error_code = ERR_TRUNC;
                            o_phase           = PH_IDLE;
                        end
                    end else if (!is_semi || !i_digit) begin
                        o_fire            = 1'b1;
                        o_item.error_code = ERR_DIGIT;
                        o_phase           = PH_IDLE;
                    end else if (too_long || too_many) begin
                        o_fire            = 1'b1;
                        o_item.error_code = ERR_LIMIT;
                        o_phase           = PH_IDLE;
                    end else if (i_acc == '0) begin
                        o_fire              = 1'b1;
                        o_item.item_kind    = KIND_EMPTY;
                        o_item.field_last   = 1'b1;
                        o_item.message_last = fin;
                        o_field             = i_field + 1'b1;
                        if (fin) begin
                            o_phase = PH_IDLE;
                        end else begin
                            o_acc   = '0;
                            o_digit = 1'b0;
                        end
                    end else if (fin) begin
                        o_fire            = 1'b1;
                        o_item.error_code = ERR_TRUNC;
                        o_phase           = PH_IDLE;
                    end else begin
                        o_rem   = i_acc;
                        o_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_fire = 1'b1;
                    if (fin && !last_byte) begin
                        o_item.error_code = ERR_TRUNC;
                        o_phase           = PH_IDLE;
                    end else begin
                        o_item.item_kind    = KIND_BYTE;
                        o_item.payload_byte = i_word.data_byte;
                        o_item.field_last   = last_byte;
                        o_item.message_last = fin;
                        if (i_rem != '0) begin
                            o_rem = i_rem - 1'b1;
                        end
                        if (last_byte) begin
                            o_field = i_field + 1'b1;
                            if (fin) begin
                                o_phase = PH_IDLE;
                            end else begin
                                o_acc   = '0;
                                o_digit = 1'b0;
                                o_phase = PH_LENGTH;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hdl/length_prefixed_field_parser.sv @@
// Top level of the decimal length-prefixed field parser.
// Results: a result word is registered and shows in the cycle after its input is taken.
// Throughput: one input word per cycle; the output register frees the input side as soon
// as the held result is taken or when none is held.
// Reset: synchronous and active low; it returns the parser to idle with no result pending
// and sets the maximum field length to 65535. The configuration port is always ready.
`default_nettype none
module length_prefixed_field_parser #(
    parameter int LENGTH_BITS = lpfp_pkg::LENGTH_BITS_DEF,
    parameter int MAX_FIELDS  = lpfp_pkg::MAX_FIELDS_DEF
) (
    input  var logic    i_clk,
    input  var logic    i_rst_n,
    lpfp_in_if.sink     i_in,
    lpfp_out_if.source  o_out,
    lpfp_cfg_if.sink    i_cfg
);
    import lpfp_pkg::*;

    localparam int FieldBits = $clog2(MAX_FIELDS + 1);

    t_phase                  r_phase, n_phase;
    logic [LENGTH_BITS-1:0]  r_acc, n_acc;
    logic [LENGTH_BITS-1:0]  r_rem, n_rem;
    logic [FieldBits-1:0]    r_field, n_field;
    logic [4:0]              r_type, n_type;
    logic                    r_digit, n_digit;
    logic [CFG_BITS-1:0]     r_max_len;
    logic                    r_out_valid;
    t_out_word               r_item, n_item;
    t_in_word                in_word;
    logic                    fire;
    logic                    in_accept;

    assign in_word   = '{data_byte: i_in.data_byte, first_byte: i_in.first_byte,
                         final_byte: i_in.final_byte};
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    lpfp_step #(
        .LENGTH_BITS (LENGTH_BITS),
        .MAX_FIELDS  (MAX_FIELDS)
    ) u_step (
        .i_word    (in_word),
        .i_max_len (r_max_len),
        .i_phase   (r_phase),
        .i_acc     (r_acc),
        .i_rem     (r_rem),
        .i_field   (r_field),
        .i_type    (r_type),
        .i_digit   (r_digit),
        .o_phase   (n_phase),
        .o_acc     (n_acc),
        .o_rem     (n_rem),
        .o_field   (n_field),
        .o_type    (n_type),
        .o_digit   (n_digit),
        .o_fire    (fire),
        .o_item    (n_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_rem       <= '0;
            r_field     <= '0;
            r_type      <= TYPE_UNKNOWN;
            r_digit     <= 1'b0;
            r_max_len   <= MAX_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_max_len <= i_cfg.data;
            end
            if (in_accept) begin
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_rem       <= n_rem;
                r_field     <= n_field;
                r_type      <= n_type;
                r_digit     <= n_digit;
                r_out_valid <= fire;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && fire) begin
            r_item <= n_item;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.item_kind    = r_item.item_kind;
    assign o_out.type_code    = r_item.type_code;
    assign o_out.field_index  = r_item.field_index;
    assign o_out.payload_byte = r_item.payload_byte;
    assign o_out.field_last   = r_item.field_last;
    assign o_out.message_last = r_item.message_last;
    assign o_out.error_code   = r_item.error_code;

endmodule
`default_nettype wire

@@ hdl/lpfp_checker.sv @@
// Port-level assertions for the field parser and the bind that attaches them.
`default_nettype none
module lpfp_checker (
    input var logic       i_clk,
    input var logic       i_rst_n,
    input var logic       i_in_ready,
    input var logic       i_out_valid,
    input var logic       i_out_ready,
    input var logic [1:0] i_item_kind,
    input var logic [2:0] i_field_index,
    input var logic [7:0] i_payload_byte,
    input var logic       i_field_last,
    input var logic       i_message_last,
    input var logic [1:0] i_error_code
);
    import lpfp_pkg::*;

    // A held output word must keep valid, kind, payload byte and error code until taken.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_item_kind)
            && $stable(i_payload_byte) && $stable(i_error_code)))
        else $error("output word changed while stalled");

    // With no word held, the parser must be able to take input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output register");

    // An error word closes the message and carries a nonzero code; other words carry none.
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_item_kind == KIND_ERROR) ?
            (i_message_last && (i_error_code != ERR_NONE)) : (i_error_code == ERR_NONE)))
        else $error("malformed error word");

    // A type word starts field counting at zero and never ends a field.
    a_type_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_item_kind == KIND_TYPE)) |->
            ((i_field_index == 3'd0) && !i_field_last && (i_payload_byte == 8'h00)))
        else $error("malformed type word");

endmodule

bind length_prefixed_field_parser lpfp_checker u_lpfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_item_kind    (o_out.item_kind),
    .i_field_index  (o_out.field_index),
    .i_payload_byte (o_out.payload_byte),
    .i_field_last   (o_out.field_last),
    .i_message_last (o_out.message_last),
    .i_error_code   (o_out.error_code)
);
`default_nettype wire

@@ bench/length_prefixed_field_parser_test.sv @@
// Self-checking testbench of the length-prefixed field parser with a predicting scoreboard.
`timescale 1ns / 100ps
module length_prefixed_field_parser_test;
    import lpfp_pkg::*;

    class parse_scoreboard;
        t_out_word   parsed_items_due[$];
        logic [15:0] max_len;
        t_phase      phase;
        int          len_acc;
        int          bytes_left;
        int          field_no;
        int          len_cap;
        logic [4:0]  msg_type;
        bit          digit_seen;
        int          checked;
        int          flagged;
        int          mismatches;

        function new();
            max_len    = MAX_LEN_RESET;
            phase      = PH_IDLE;
            len_acc    = 0;
            bytes_left = 0;
            field_no   = 0;
            len_cap    = (1 << LENGTH_BITS_DEF) - 1;
            msg_type   = TYPE_UNKNOWN;
            digit_seen = 1'b0;
            checked    = 0;
            flagged    = 0;
            mismatches = 0;
        endfunction

        function void set_max_len(logic [15:0] v);
            max_len = v;
        endfunction

        function int items_due();
            return parsed_items_due.size();
        endfunction

        function logic [4:0] letter_code(logic [7:0] b);
            string letters;
            letters = "LSRIGBEZXJTACFVW";
            for (int k = 0; k < 16; k++) begin
                if (8'(letters[k]) == b) begin
                    return 5'(k);
                end
            end
            return TYPE_UNKNOWN;
        endfunction

        function void push_item(t_kind kind, int fidx, logic [7:0] pay, bit flast, bit mlast,
                                t_err err);
            t_out_word w;
            w.item_kind    = kind;
            w.type_code    = msg_type;
            w.field_index  = fidx[2:0];
            w.payload_byte = pay;
            w.field_last   = flast;
            w.message_last = mlast;
            w.error_code   = err;
            if (kind == KIND_ERROR) begin
                flagged++;
            end
            parsed_items_due.insert(parsed_items_due.size(), w);
        endfunction

        function void abort_message(t_err err);
            push_item(KIND_ERROR, field_no, 8'h00, 1'b0, 1'b1, err);
            phase = PH_IDLE;
        endfunction

        function void open_length();
            len_acc    = 0;
            digit_seen = 1'b0;
            phase      = PH_LENGTH;
        endfunction

        function void note_byte(t_in_word w);
            logic [7:0] b;
            bit         fin;
            bit         last;
            int         d;
            b   = w.data_byte;
            fin = w.final_byte;
            if (w.first_byte) begin
                msg_type   = letter_code(b);
                field_no   = 0;
                bytes_left = 0;
                push_item(KIND_TYPE, 0, 8'h00, 1'b0, fin, ERR_NONE);
                if (fin) begin
                    phase = PH_IDLE;
                end else begin
                    open_length();
                end
            end else if (phase == PH_LENGTH) begin
                if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                    d = int'(b - CHAR_ZERO);
                    if (len_acc > (len_cap - d) / 10) begin
                        len_acc = len_cap;
                    end else begin
                        len_acc = len_acc * 10 + d;
                    end
                    digit_seen = 1'b1;
                    if (fin) begin
                        abort_message(ERR_TRUNC);
                    end
                end else if (b != CHAR_SEMI || !digit_seen) begin
                    abort_message(ERR_DIGIT);
                end else if (len_acc > int'(max_len) || field_no >= MAX_FIELDS_DEF) begin
                    abort_message(ERR_LIMIT);
                end else if (len_acc == 0) begin
                    push_item(KIND_EMPTY, field_no, 8'h00, 1'b1, fin, ERR_NONE);
                    field_no++;
                    if (fin) begin
                        phase = PH_IDLE;
                    end else begin
                        open_length();
                    end
                end else if (fin) begin
                    abort_message(ERR_TRUNC);
                end else begin
                    bytes_left = len_acc;
                    phase      = PH_PAYLOAD;
                end
            end else if (phase == PH_PAYLOAD) begin
                last = (bytes_left <= 1);
                if (fin && !last) begin
                    abort_message(ERR_TRUNC);
                end else begin
                    push_item(KIND_BYTE, field_no, b, last, fin, ERR_NONE);
                    if (bytes_left > 0) begin
                        bytes_left--;
                    end
                    if (last) begin
                        field_no++;
                        if (fin) begin
                            phase = PH_IDLE;
                        end else begin
                            open_length();
                        end
                    end
                end
            end
        endfunction

        function string item_text(t_out_word w);
            return $sformatf("kind %0d type %0d field %0d byte %02h flast %0b mlast %0b err %0d",
                             w.item_kind, w.type_code, w.field_index, w.payload_byte,
                             w.field_last, w.message_last, w.error_code);
        endfunction

        function void check_item(t_out_word got);
            t_out_word want;
            checked++;
            if (parsed_items_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: %s", item_text(got));
                end
                return;
            end
            want = parsed_items_due.pop_front();
            if (got.item_kind !== want.item_kind || got.type_code !== want.type_code ||
                got.field_index !== want.field_index || got.payload_byte !== want.payload_byte ||
                got.field_last !== want.field_last || got.message_last !== want.message_last ||
                got.error_code !== want.error_code) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("item %0d expected: %s", checked, item_text(want));
                    $display("item %0d actual:   %s", checked, item_text(got));
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic hold_active = 1'b0;
    int   in_idle_pct = 0;
    int   out_stall_pct = 0;
    int   words_sent = 0;
    int   messages = 0;
    int   limits_written = 0;
    string type_chars = "LSRIGBEZXJTACFVW";
    t_in_word stim_words[$];
    event start_hold;
    parse_scoreboard board = new();

    lpfp_in_if  in_if ();
    lpfp_out_if out_if ();
    lpfp_cfg_if cfg_if ();

    length_prefixed_field_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(start_hold) begin
        hold_active <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin : out_side
        t_out_word got;
        got.item_kind    = t_kind'(out_if.item_kind);
        got.type_code    = out_if.type_code;
        got.field_index  = out_if.field_index;
        got.payload_byte = out_if.payload_byte;
        got.field_last   = out_if.field_last;
        got.message_last = out_if.message_last;
        got.error_code   = t_err'(out_if.error_code);
        if (out_if.valid && out_if.ready) begin
            board.check_item(got);
        end
        out_if.ready <= !hold_active && ($urandom_range(99) >= out_stall_pct);
    end

    task automatic put_word(logic [7:0] b, bit first, bit fin);
        t_in_word w;
        w.data_byte  = b;
        w.first_byte = first;
        w.final_byte = fin;
        stim_words.insert(stim_words.size(), w);
    endtask

    task automatic put_text(string s, bit close);
        for (int k = 0; k < s.len(); k++) begin
            put_word(8'(s[k]), k == 0, close && k == s.len() - 1);
        end
    endtask

    task automatic add_message();
        logic [7:0] mb[$];
        string      digits;
        int         nf;
        int         len;
        int         pick;
        int         n;
        int         keep;
        bit         open_end;
        open_end = 1'b0;
        if ($urandom_range(9) != 0) begin
            mb.insert(mb.size(), 8'(type_chars[$urandom_range(15)]));
        end else begin
            mb.insert(mb.size(), 8'($urandom_range(255)));
        end
        pick = $urandom_range(19);
        if (pick == 0) begin
            nf = $urandom_range(11, 9);
        end else if (pick < 3) begin
            nf = 0;
        end else begin
            nf = $urandom_range(4, 1);
        end
        for (int f = 0; f < nf; f++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                len = $urandom_range(3, 0);
            end else if (pick < 75) begin
                len = $urandom_range(12, 4);
            end else if (pick < 92) begin
                len = $urandom_range(30, 13);
            end else begin
                len = $urandom_range(99999, 31);
            end
            digits = $sformatf("%0d", len);
            pick = $urandom_range(29);
            if (pick == 0) begin
                digits = "";
            end else if (pick < 4) begin
                digits = {"0", digits};
            end
            for (int k = 0; k < digits.len(); k++) begin
                mb.insert(mb.size(), 8'(digits[k]));
            end
            mb.insert(mb.size(), CHAR_SEMI);
            n = (len > 40) ? 40 : len;
            repeat (n) mb.insert(mb.size(), 8'($urandom_range(255)));
            if (len > 40) begin
                break;
            end
        end
        pick = $urandom_range(99);
        n = mb.size();
        if (pick < 6 && n > 1) begin
            mb[$urandom_range(n - 1, 1)] = 8'($urandom_range(255));
        end else if (pick < 14 && n > 1) begin
            keep = $urandom_range(n - 1, 1);
            while (mb.size() > keep) begin
                void'(mb.pop_back());
            end
        end else if (pick < 18) begin
            open_end = 1'b1;
        end
        for (int i = 0; i < mb.size(); i++) begin
            put_word(mb[i], i == 0, i == mb.size() - 1 && !open_end);
        end
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(3, 1)) begin
                put_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
            end
        end
        messages++;
    endtask

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= w.data_byte;
        in_if.first_byte <= w.first_byte;
        in_if.final_byte <= w.final_byte;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_byte(w);
        words_sent++;
    endtask

    task automatic send_all();
        while (stim_words.size() != 0) begin
            send_word(stim_words.pop_front());
        end
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (board.items_due() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        board.set_max_len(v);
        limits_written++;
    endtask

    initial begin
        int limit_steps[8];
        int target;
        limit_steps = '{65535, 0, 5, 1, 20, 300, 65535, 12};
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= 8'h00;
        in_if.first_byte <= 1'b0;
        in_if.final_byte <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.data      <= 16'h0000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_limit(16'hFFFF);
        put_text("L", 1'b1);
        put_text("W0;2;", 1'b0);
        put_word(8'h00, 1'b0, 1'b0);
        put_word(8'hFF, 1'b0, 1'b1);
        put_text("q;", 1'b0);
        put_text("S1a", 1'b0);
        put_text("R70000;", 1'b1);
        put_text("I3", 1'b1);
        put_text("G1", 1'b0);
        put_text("B", 1'b1);
        send_all();
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_limit(16'(limit_steps[p]));
            case (p % 4)
                0: begin
                    in_idle_pct = 0;
                    out_stall_pct <= 0;
                end
                1: begin
                    in_idle_pct = 88;
                    out_stall_pct <= 0;
                end
                2: begin
                    in_idle_pct = 0;
                    out_stall_pct <= 88;
                end
                default: begin
                    in_idle_pct = 17;
                    out_stall_pct <= 17;
                end
            endcase
            if (p == 0) begin
                -> start_hold;
            end
            target = words_sent + 120;
            while (words_sent < target) begin
                add_message();
                send_all();
            end
            wait_drained();
        end

        $display("Fed %0d words in %0d messages under %0d length limit writes and four",
                 words_sent, messages, limits_written);
        $display("flow-control mixes; checked %0d result words, %0d of them error reports.",
                 board.checked, board.flagged);
        if (board.mismatches == 0 && board.items_due() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
